FILE: rtl/core/bmg_pkg.sv
// bmg_pkg: shared types and constants of the gaussian generator
// holds the iterative unit control struct and the series constant tables
// no dependencies
`default_nettype none
package bmg_pkg;

	typedef enum logic {
		ITER_DIV  = 1'b0,
		ITER_SQRT = 1'b1
	} iter_mode_t;

	typedef struct packed {
		logic       start;
		iter_mode_t mode;
	} iter_ctl_t;

	localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd0;
	localparam logic [1:0] CFG_TARGET_MEAN  = 2'd1;
	localparam logic [1:0] CFG_TARGET_SIGMA = 2'd2;

	localparam logic [30:0] ONE_Q30     = 31'h40000000;
	localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

	// series term divisor, innermost term first
	function automatic logic [6:0] series_k(input logic sin_sel, input logic [2:0] idx);
		logic [6:0] k;
		k = 7'd2;
		case (idx)
			3'd0: k = sin_sel ? 7'd110 : 7'd90;
			3'd1: k = sin_sel ? 7'd72  : 7'd56;
			3'd2: k = sin_sel ? 7'd42  : 7'd30;
			3'd3: k = sin_sel ? 7'd20  : 7'd12;
			3'd4: k = sin_sel ? 7'd6   : 7'd2;
			default: k = 7'd2;
		endcase
		return k;
	endfunction

	// floor(2^32 / k) for the divisor above
	function automatic logic [31:0] series_m(input logic sin_sel, input logic [2:0] idx);
		logic [31:0] m;
		m = 32'd2147483648;
		case (idx)
			3'd0: m = sin_sel ? 32'd39045157  : 32'd47721858;
			3'd1: m = sin_sel ? 32'd59652323  : 32'd76695844;
			3'd2: m = sin_sel ? 32'd102261126 : 32'd143165576;
			3'd3: m = sin_sel ? 32'd214748364 : 32'd357913941;
			3'd4: m = sin_sel ? 32'd715827882 : 32'd2147483648;
			default: m = 32'd2147483648;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bmg_mul.sv
// bmg_mul: shared 32 x 32 unsigned multiplier
// product is captured by the sequencer registers; no dependencies
`default_nettype none
module bmg_mul (
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [63:0] p
);
	assign p = 64'(a) * 64'(b);
endmodule
`default_nettype wire

FILE: rtl/core/bmg_iter.sv
// bmg_iter: shared iterative unit, restoring divide (one bit a cycle)
// and restoring square root (one root bit a cycle); uses bmg_pkg
`default_nettype none
module bmg_iter #(
	parameter int DW = 17
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bmg_pkg::iter_ctl_t  ctl,
	input  wire logic [63:0]         operand,
	input  wire logic [DW-1:0]       divisor,
	output logic                     busy,
	output logic [63:0]              result
);
	import bmg_pkg::*;

	localparam int SW = (DW + 1 > 35) ? DW + 1 : 35;
	localparam logic [6:0] DIV_STEPS  = 7'd64;
	localparam logic [6:0] SQRT_STEPS = 7'd32;

	logic          busy_q;
	iter_mode_t    mode_q;
	logic [6:0]    cnt_q;
	logic [63:0]   x_q;
	logic [SW-1:0] rem_q;
	logic [63:0]   q_q;
	logic [DW-1:0] dv_q;

	logic [SW-1:0] cand;
	logic [SW-1:0] dsub;
	logic [SW:0]   diff;
	logic          ge;

	always_comb begin
		if (mode_q == ITER_DIV) begin
			cand = {rem_q[SW-2:0], x_q[63]};
			dsub = SW'(dv_q);
		end else begin
			cand = {rem_q[SW-3:0], x_q[63:62]};
			dsub = SW'({q_q[31:0], 2'b01});
		end
		diff = {1'b0, cand} - {1'b0, dsub};
		ge   = ~diff[SW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= (ctl.mode == ITER_DIV) ? DIV_STEPS : SQRT_STEPS;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mode_q <= ctl.mode;
			x_q    <= operand;
			rem_q  <= '0;
			q_q    <= '0;
			dv_q   <= divisor;
		end else if (busy_q) begin
			x_q   <= (mode_q == ITER_DIV) ? {x_q[62:0], 1'b0} : {x_q[61:0], 2'b00};
			rem_q <= ge ? diff[SW-1:0] : cand;
			q_q   <= {q_q[62:0], ge};
		end
	end

	assign busy   = busy_q;
	assign result = q_q;
endmodule
`default_nettype wire

FILE: rtl/core/box_muller_gaussian_generator.sv
// box_muller_gaussian_generator: the time from accept to result is set by the 24 squaring
// steps of the log and the 32-step square root; the last item of a batch also runs two
// 64-step divides and one 32-step root for the batch statistics.
// One item at a time; the next item is taken while a result waits at the output.
// Asynchronous active-low reset clears config to defaults and the batch statistics.
`default_nettype none
module box_muller_gaussian_generator #(
	parameter int MAX_BATCH = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] uniform_a,
	input  wire logic [31:0] uniform_b,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      sample,
	output logic             batch_done,
	output logic [31:0]      estimated_mean,
	output logic [30:0]      estimated_std
);
	import bmg_pkg::*;

	localparam int CW   = $clog2(MAX_BATCH + 1);
	localparam int SUMW = 32 + $clog2(MAX_BATCH);
	localparam int SQW  = 47 + $clog2(MAX_BATCH);
	localparam logic [16:0] MAX_LIMIT = 17'(MAX_BATCH);
	localparam logic [4:0]  SQ_LAST   = 5'd23;
	localparam logic [2:0]  NORM_LAST = 3'd4;
	localparam logic [2:0]  TERM_LAST = 3'd4;

	typedef enum logic [21:0] {
		ST_IDLE  = 22'h000001,
		ST_NORM  = 22'h000002,
		ST_SQR   = 22'h000004,
		ST_LNT   = 22'h000008,
		ST_PHI   = 22'h000010,
		ST_PSQ   = 22'h000020,
		ST_T1    = 22'h000040,
		ST_T2    = 22'h000080,
		ST_T3    = 22'h000100,
		ST_SIN   = 22'h000200,
		ST_WAITR = 22'h000400,
		ST_ZM    = 22'h000800,
		ST_DM    = 22'h001000,
		ST_SS    = 22'h002000,
		ST_SQ    = 22'h004000,
		ST_MDIV  = 22'h008000,
		ST_MDIVW = 22'h010000,
		ST_MSQ   = 22'h020000,
		ST_VDIVW = 22'h040000,
		ST_VSQ   = 22'h080000,
		ST_VSQW  = 22'h100000,
		ST_OUT   = 22'h200000
	} state_t;

	state_t state_q;

	// config
	logic [16:0] sample_count_q;
	logic [31:0] target_mean_q;
	logic [30:0] target_sigma_q;

	// batch state
	logic [CW-1:0]          samples_seen_q;
	logic signed [SUMW-1:0] running_sum_q;
	logic [SQW-1:0]         running_square_sum_q;
	logic                   batch_q;

	// sequencer counters
	logic [2:0] nstep_q;
	logic [4:0] sq_q;
	logic [2:0] kidx_q;

	// datapath
	logic [31:0] f_q;
	logic [5:0]  e_q;
	logic [23:0] frac_q;
	logic [29:0] x_q;
	logic [1:0]  quad_q;
	logic        use_cos_q;
	logic        neg_q;
	logic [29:0] phi_q;
	logic [29:0] p_q;
	logic [30:0] t_q;
	logic [29:0] n_q;
	logic [29:0] q0_q;
	logic [18:0] r_q;
	logic [18:0] zmag_q;
	logic [33:0] dmag_q;
	logic [31:0] s_q;
	logic [31:0] mm_q;
	logic [47:0] msq_q;
	logic [47:0] var_q;
	logic [30:0] sd_q;

	// output register
	logic        out_valid_q;
	logic [31:0] sample_q;
	logic        batch_done_q;
	logic [31:0] emean_q;
	logic [30:0] estd_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	iter_ctl_t   iter_ctl;
	logic [63:0] iter_a;
	logic        iter_busy;
	logic [63:0] iter_res;

	logic        in_acc;
	logic        out_load;
	logic [29:0] tl;
	logic [30:0] xa_w;
	logic [6:0]  kval;
	logic [31:0] mval;
	logic [29:0] rem_w;
	logic [29:0] qq_w;
	logic signed [35:0] sum36;
	logic [31:0] mag_w;
	logic [CW-1:0] count_w;
	logic [CW-1:0] limit_w;
	logic [SUMW-1:0] abs_sum;
	logic [31:0] sat_s;

	bmg_mul u_mul (
		.a (mul_a),
		.b (mul_b),
		.p (prod)
	);

	bmg_iter #(.DW(CW)) u_iter (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (iter_ctl),
		.operand (iter_a),
		.divisor (samples_seen_q),
		.busy    (iter_busy),
		.result  (iter_res)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		tl      = {6'd32 - e_q, 24'd0} - {6'd0, frac_q};
		xa_w    = x_q[29] ? (ONE_Q30 - {1'b0, x_q}) : {1'b0, x_q};
		kval    = series_k(~use_cos_q, kidx_q);
		mval    = series_m(~use_cos_q, kidx_q);
		rem_w   = n_q - prod[29:0];
		qq_w    = q0_q + ((rem_w >= 30'(kval)) ? 30'd1 : 30'd0);
		mag_w   = s_q[31] ? (32'd0 - s_q) : s_q;
		count_w = samples_seen_q + CW'(1);
		abs_sum = running_sum_q[SUMW-1] ? SUMW'(-running_sum_q) : SUMW'(running_sum_q);
		if (sample_count_q == 17'd0) begin
			limit_w = CW'(1);
		end else if (sample_count_q > MAX_LIMIT) begin
			limit_w = CW'(MAX_BATCH);
		end else begin
			limit_w = sample_count_q[CW-1:0];
		end
		if (neg_q) begin
			sum36 = 36'($signed(target_mean_q)) - $signed({2'b00, dmag_q});
		end else begin
			sum36 = 36'($signed(target_mean_q)) + $signed({2'b00, dmag_q});
		end
		if (sum36 > 36'sd2147483647) begin
			sat_s = 32'h7FFFFFFF;
		end else if (sum36 < -36'sd2147483648) begin
			sat_s = 32'h80000000;
		end else begin
			sat_s = sum36[31:0];
		end
	end

	// operand selection for the shared units
	always_comb begin
		mul_a         = '0;
		mul_b         = '0;
		iter_ctl      = '{start: 1'b0, mode: ITER_DIV};
		iter_a        = '0;
		case (state_q)
			ST_SQR: begin
				mul_a = f_q;
				mul_b = f_q;
			end
			ST_LNT: begin
				mul_a    = {2'b00, tl};
				mul_b    = {1'b0, TWO_LN2_Q30};
				iter_ctl = '{start: 1'b1, mode: ITER_SQRT};
				iter_a   = {25'd0, prod[60:30], 8'd0};
			end
			ST_PHI: begin
				mul_a = {2'b00, xa_w[29:0]};
				mul_b = {1'b0, HALF_PI_Q30};
			end
			ST_PSQ: begin
				mul_a = {2'b00, phi_q};
				mul_b = {2'b00, phi_q};
			end
			ST_T1: begin
				mul_a = {2'b00, p_q};
				mul_b = {1'b0, t_q};
			end
			ST_T2: begin
				mul_a = {2'b00, n_q};
				mul_b = mval;
			end
			ST_T3: begin
				mul_a = {2'b00, q0_q};
				mul_b = {25'd0, kval};
			end
			ST_SIN: begin
				mul_a = {2'b00, phi_q};
				mul_b = {1'b0, t_q};
			end
			ST_ZM: begin
				mul_a = {13'd0, r_q};
				mul_b = {1'b0, t_q};
			end
			ST_DM: begin
				mul_a = {13'd0, zmag_q};
				mul_b = {1'b0, target_sigma_q};
			end
			ST_SQ: begin
				mul_a = mag_w;
				mul_b = mag_w;
			end
			ST_MDIV: begin
				iter_ctl = '{start: 1'b1, mode: ITER_DIV};
				iter_a   = 64'(abs_sum);
			end
			ST_MSQ: begin
				mul_a    = mm_q;
				mul_b    = mm_q;
				iter_ctl = '{start: 1'b1, mode: ITER_DIV};
				iter_a   = 64'(running_square_sum_q);
			end
			ST_VSQ: begin
				iter_ctl = '{start: 1'b1, mode: ITER_SQRT};
				iter_a   = {var_q, 16'd0};
			end
			default: begin
			end
		endcase
	end

	// control, config and batch state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q              <= ST_IDLE;
			out_valid_q          <= 1'b0;
			sample_count_q       <= 17'd1000;
			target_mean_q        <= 32'd0;
			target_sigma_q       <= 31'd65536;
			samples_seen_q       <= '0;
			running_sum_q        <= '0;
			running_square_sum_q <= '0;
			batch_q              <= 1'b0;
			nstep_q              <= '0;
			sq_q                 <= '0;
			kidx_q               <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SAMPLE_COUNT: sample_count_q <= cfg_data[16:0];
					CFG_TARGET_MEAN:  target_mean_q  <= cfg_data;
					CFG_TARGET_SIGMA: target_sigma_q <= cfg_data[30:0];
					default: begin
					end
				endcase
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						nstep_q <= '0;
						sq_q    <= '0;
						state_q <= (&uniform_a) ? ST_SQR : ST_NORM;
					end
				end
				ST_NORM: begin
					nstep_q <= nstep_q + 3'd1;
					if (nstep_q == NORM_LAST) begin
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					sq_q <= sq_q + 5'd1;
					if (sq_q == SQ_LAST) begin
						state_q <= ST_LNT;
					end
				end
				ST_LNT: state_q <= ST_PHI;
				ST_PHI: state_q <= ST_PSQ;
				ST_PSQ: begin
					kidx_q  <= '0;
					state_q <= ST_T1;
				end
				ST_T1: state_q <= ST_T2;
				ST_T2: state_q <= ST_T3;
				ST_T3: begin
					kidx_q <= kidx_q + 3'd1;
					if (kidx_q == TERM_LAST) begin
						state_q <= use_cos_q ? ST_WAITR : ST_SIN;
					end else begin
						state_q <= ST_T1;
					end
				end
				ST_SIN: state_q <= ST_WAITR;
				ST_WAITR: begin
					if (!iter_busy) begin
						state_q <= ST_ZM;
					end
				end
				ST_ZM: state_q <= ST_DM;
				ST_DM: state_q <= ST_SS;
				ST_SS: state_q <= ST_SQ;
				ST_SQ: begin
					running_sum_q        <= running_sum_q + SUMW'($signed(s_q));
					running_square_sum_q <= running_square_sum_q + SQW'(prod[63:16]);
					samples_seen_q       <= count_w;
					batch_q              <= (count_w >= limit_w);
					state_q              <= (count_w >= limit_w) ? ST_MDIV : ST_OUT;
				end
				ST_MDIV: state_q <= ST_MDIVW;
				ST_MDIVW: begin
					if (!iter_busy) begin
						state_q <= ST_MSQ;
					end
				end
				ST_MSQ: state_q <= ST_VDIVW;
				ST_VDIVW: begin
					if (!iter_busy) begin
						state_q <= ST_VSQ;
					end
				end
				ST_VSQ: state_q <= ST_VSQW;
				ST_VSQW: begin
					if (!iter_busy) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (batch_q) begin
							samples_seen_q       <= '0;
							running_sum_q        <= '0;
							running_square_sum_q <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					f_q    <= (&uniform_a) ? 32'h80000000 : uniform_a + 32'd1;
					e_q    <= (&uniform_a) ? 6'd32 : 6'd31;
					frac_q <= '0;
					x_q    <= uniform_b[29:0];
					quad_q <= uniform_b[31:30];
				end
			end
			ST_NORM: begin
				case (nstep_q)
					3'd0: if (f_q[31:16] == 16'd0) begin
						f_q <= {f_q[15:0], 16'd0};
						e_q <= e_q - 6'd16;
					end
					3'd1: if (f_q[31:24] == 8'd0) begin
						f_q <= {f_q[23:0], 8'd0};
						e_q <= e_q - 6'd8;
					end
					3'd2: if (f_q[31:28] == 4'd0) begin
						f_q <= {f_q[27:0], 4'd0};
						e_q <= e_q - 6'd4;
					end
					3'd3: if (f_q[31:30] == 2'd0) begin
						f_q <= {f_q[29:0], 2'd0};
						e_q <= e_q - 6'd2;
					end
					default: if (!f_q[31]) begin
						f_q <= {f_q[30:0], 1'b0};
						e_q <= e_q - 6'd1;
					end
				endcase
			end
			ST_SQR: begin
				if (prod[63]) begin
					f_q    <= prod[63:32];
					frac_q <= {frac_q[22:0], 1'b1};
				end else begin
					f_q    <= prod[62:31];
					frac_q <= {frac_q[22:0], 1'b0};
				end
			end
			ST_PHI: begin
				phi_q     <= prod[59:30];
				use_cos_q <= ~(x_q[29] ^ quad_q[0]);
				neg_q     <= quad_q[1] ^ quad_q[0];
			end
			ST_PSQ: begin
				p_q <= prod[59:30];
				t_q <= ONE_Q30;
			end
			ST_T1: n_q <= prod[59:30];
			ST_T2: q0_q <= prod[61:32];
			ST_T3: t_q <= ONE_Q30 - {1'b0, qq_w};
			ST_SIN: t_q <= prod[60:30];
			ST_WAITR: begin
				if (!iter_busy) begin
					r_q <= iter_res[18:0];
				end
			end
			ST_ZM: zmag_q <= prod[48:30];
			ST_DM: dmag_q <= prod[49:16];
			ST_SS: s_q <= sat_s;
			ST_MDIVW: begin
				if (!iter_busy) begin
					mm_q <= iter_res[31:0];
				end
			end
			ST_MSQ: msq_q <= prod[63:16];
			ST_VDIVW: begin
				if (!iter_busy) begin
					var_q <= (iter_res[47:0] > msq_q) ? iter_res[47:0] - msq_q : 48'd0;
				end
			end
			ST_VSQW: begin
				if (!iter_busy) begin
					sd_q <= iter_res[31] ? 31'h7FFFFFFF : iter_res[30:0];
				end
			end
			ST_OUT: begin
				if (out_load) begin
					sample_q     <= s_q;
					batch_done_q <= batch_q;
					if (batch_q) begin
						emean_q <= running_sum_q[SUMW-1] ? (32'd0 - mm_q) : mm_q;
						estd_q  <= sd_q;
					end else begin
						emean_q <= '0;
						estd_q  <= '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign sample         = sample_q;
	assign batch_done     = batch_done_q;
	assign estimated_mean = emean_q;
	assign estimated_std  = estd_q;
endmodule
`default_nettype wire

FILE: tb/bmg_checker.sv
// bmg_checker: watches the item channels of the gaussian generator, predicts each result
// from its own copy of the batch state and configuration, and counts mismatches
// depends on bmg_pkg for the register index codes and constants
module bmg_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] uniform_a,
	input  logic [31:0] uniform_b,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] sample,
	input  logic        batch_done,
	input  logic [31:0] estimated_mean,
	input  logic [30:0] estimated_std,
	output int          errors,
	output int          pending
);
	import bmg_pkg::*;

	localparam int BATCH_MAX = 65536;
	localparam logic [63:0] Q30 = 64'(ONE_Q30);

	typedef struct packed {
		logic [31:0] smp;
		logic        done;
		logic [31:0] mean;
		logic [30:0] sd;
	} gauss_result_t;

	gauss_result_t gauss_q[$];

	logic [16:0] batch_len;
	longint      mean_off;
	logic [63:0] sigma;
	logic [16:0] seen;
	longint      acc_sum;
	logic [63:0] acc_sq;

	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] neg_two_ln(input logic [31:0] code);
		logic [63:0] v;
		logic [63:0] f;
		logic [63:0] frac;
		logic [63:0] t;
		int e;
		v = 64'(code) + 64'd1;
		e = 0;
		frac = 0;
		while (e < 32 && (v >> (e + 1)) != 0)
			e++;
		f = (e <= 31) ? (v << (31 - e)) : (v >> 1);
		for (int i = 0; i < 24; i++) begin
			f = (f * f) >> 31;
			frac = frac << 1;
			if (f >= (64'd1 << 32)) begin
				f = f >> 1;
				frac = frac | 64'd1;
			end
		end
		t = (64'd32 << 24) - ((64'(e) << 24) | frac);
		return (t * 64'(TWO_LN2_Q30)) >> 30;
	endfunction

	function automatic logic [63:0] cos_series(input logic [63:0] phi);
		logic [63:0] p;
		logic [63:0] t;
		p = (phi * phi) >> 30;
		t = Q30;
		t = Q30 - ((p * t) >> 30) / 90;
		t = Q30 - ((p * t) >> 30) / 56;
		t = Q30 - ((p * t) >> 30) / 30;
		t = Q30 - ((p * t) >> 30) / 12;
		t = Q30 - ((p * t) >> 30) / 2;
		return t;
	endfunction

	function automatic logic [63:0] sin_series(input logic [63:0] phi);
		logic [63:0] p;
		logic [63:0] t;
		p = (phi * phi) >> 30;
		t = Q30;
		t = Q30 - ((p * t) >> 30) / 110;
		t = Q30 - ((p * t) >> 30) / 72;
		t = Q30 - ((p * t) >> 30) / 42;
		t = Q30 - ((p * t) >> 30) / 20;
		t = Q30 - ((p * t) >> 30) / 6;
		return (phi * t) >> 30;
	endfunction

	// magnitude of cos(2 pi code / 2^32) in Q2.30, sign in bit 64
	function automatic logic [64:0] turn_cosine(input logic [31:0] code);
		logic [63:0] x;
		logic [63:0] phi;
		logic [63:0] c;
		logic [63:0] s;
		x = 64'(code[29:0]);
		if (x < (64'd1 << 29)) begin
			phi = (x * 64'(HALF_PI_Q30)) >> 30;
			c = cos_series(phi);
			s = sin_series(phi);
		end else begin
			phi = ((Q30 - x) * 64'(HALF_PI_Q30)) >> 30;
			c = sin_series(phi);
			s = cos_series(phi);
		end
		case (code[31:30])
			2'd0: return {1'b0, c};
			2'd1: return {1'b1, s};
			2'd2: return {1'b1, c};
			default: return {1'b0, s};
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		gauss_result_t exp_r;
		logic [64:0]   cs;
		logic [63:0]   r;
		logic [63:0]   dmag;
		logic [63:0]   mag;
		logic [63:0]   msq;
		logic [63:0]   ms;
		logic [63:0]   var_q;
		logic [63:0]   sd;
		longint        s;
		longint        mean;
		int            cnt;
		int            lim;
		if (!arst_n) begin
			batch_len <= 17'd1000;
			mean_off <= 0;
			sigma <= 64'd65536;
			seen <= 0;
			acc_sum <= 0;
			acc_sq <= 0;
			errors <= 0;
			pending <= 0;
			gauss_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (gauss_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected result sample=%h", sample);
					errors <= errors + 1;
				end else begin
					exp_r = gauss_q.pop_front();
					if (exp_r.smp !== sample || exp_r.done !== batch_done ||
							exp_r.mean !== estimated_mean || exp_r.sd !== estimated_std) begin
						if (errors < 10)
							$display("mismatch exp %h %b %h %h got %h %b %h %h",
								exp_r.smp, exp_r.done, exp_r.mean, exp_r.sd,
								sample, batch_done, estimated_mean, estimated_std);
						errors <= errors + 1;
					end
				end
			end
			if (in_valid && in_ready) begin
				r = isqrt(neg_two_ln(uniform_a) << 8);
				cs = turn_cosine(uniform_b);
				dmag = (((r * cs[63:0]) >> 30) * sigma) >> 16;
				s = cs[64] ? mean_off - longint'(dmag) : mean_off + longint'(dmag);
				if (s > 64'sd2147483647)
					s = 64'sd2147483647;
				if (s < -64'sd2147483648)
					s = -64'sd2147483648;
				mag = (s < 0) ? 64'(-s) : 64'(s);
				cnt = int'(seen) + 1;
				lim = int'(batch_len);
				if (lim < 1)
					lim = 1;
				if (lim > BATCH_MAX)
					lim = BATCH_MAX;
				exp_r = '0;
				exp_r.smp = s[31:0];
				if (cnt >= lim) begin
					mean = (acc_sum + s) / longint'(cnt);
					msq = ((mean < 0 ? 64'(-mean) : 64'(mean)) ** 2) >> 16;
					ms = (acc_sq + ((mag * mag) >> 16)) / 64'(cnt);
					var_q = (ms > msq) ? ms - msq : 64'd0;
					sd = isqrt(var_q << 16);
					if (sd > 64'h7FFFFFFF)
						sd = 64'h7FFFFFFF;
					exp_r.done = 1'b1;
					exp_r.mean = mean[31:0];
					exp_r.sd = sd[30:0];
					seen <= 0;
					acc_sum <= 0;
					acc_sq <= 0;
				end else begin
					seen <= 17'(cnt);
					acc_sum <= acc_sum + s;
					acc_sq <= acc_sq + ((mag * mag) >> 16);
				end
				gauss_q.push_back(exp_r);
			end
			pending <= gauss_q.size();
			if (cfg_we) begin
				case (cfg_index)
					CFG_SAMPLE_COUNT: batch_len <= cfg_data[16:0];
					CFG_TARGET_MEAN: mean_off <= longint'(signed'(cfg_data));
					CFG_TARGET_SIGMA: sigma <= 64'(cfg_data[30:0]);
					default: ;
				endcase
			end
		end
	end
endmodule

FILE: tb/tb_box_muller_gaussian_generator.sv
// tb_box_muller_gaussian_generator: drives configuration phases and uniform items into
// the gaussian generator with random idling on both sides; bmg_checker judges results
// depends on bmg_pkg, bmg_checker and box_muller_gaussian_generator
module tb_box_muller_gaussian_generator;
	import bmg_pkg::*;

	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] uniform_a;
	logic [31:0] uniform_b;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] sample;
	logic        batch_done;
	logic [31:0] estimated_mean;
	logic [30:0] estimated_std;
	int          errors;
	int          pending;
	int          tx_idle_pct;
	int          rx_stall_pct;
	int          quiet_cycles;

	box_muller_gaussian_generator u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.uniform_a(uniform_a), .uniform_b(uniform_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.sample(sample), .batch_done(batch_done),
		.estimated_mean(estimated_mean), .estimated_std(estimated_std)
	);

	bmg_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.uniform_a(uniform_a), .uniform_b(uniform_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.sample(sample), .batch_done(batch_done),
		.estimated_mean(estimated_mean), .estimated_std(estimated_std),
		.errors(errors), .pending(pending)
	);

	always #10 clk = ~clk;

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= rx_stall_pct);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL box_muller_gaussian_generator");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic push_uniform(input logic [31:0] a, input logic [31:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		uniform_a <= a;
		uniform_b <= b;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// sender holds off until every result is back, then lets the block settle
	task automatic drain;
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic random_uniforms(input int n);
		logic [31:0] a;
		logic [31:0] b;
		for (int i = 0; i < n; i++) begin
			a = $urandom;
			b = $urandom;
			case ($urandom_range(15))
				0: a = 32'h0;
				1: a = 32'hFFFFFFFF;
				2: b = {2'($urandom_range(3)), 30'h0};
				default: ;
			endcase
			push_uniform(a, b);
		end
	endtask

	task automatic set_batch(input logic [31:0] len, input logic [31:0] mean,
			input logic [31:0] sig);
		write_reg(CFG_SAMPLE_COUNT, len);
		write_reg(CFG_TARGET_MEAN, mean);
		write_reg(CFG_TARGET_SIGMA, sig);
	endtask

	initial begin
		logic [31:0] dir_a [0:9];
		logic [31:0] dir_b [0:9];
		dir_a = '{32'h0, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h1, 32'h80000000,
			32'hFFFFFFFE, 32'h0000FFFF, 32'h12345678, 32'hFFFFFFFF, 32'h0};
		dir_b = '{32'h0, 32'h40000000, 32'h80000000, 32'hC0000000, 32'h1FFFFFFF,
			32'h20000000, 32'h3FFFFFFF, 32'hFFFFFFFF, 32'hA0000000, 32'h60000000};
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SAMPLE_COUNT;
		cfg_data = '0;
		in_valid = 1'b0;
		uniform_a = '0;
		uniform_b = '0;
		out_ready = 1'b0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		for (int i = 0; i < 10; i++)
			push_uniform(dir_a[i], dir_b[i]);
		for (int i = 0; i < 10; i++)
			push_uniform(dir_a[i], dir_b[9 - i]);
		drain();

		// zero batch length acts as one
		set_batch(32'd0, 32'h80000000, 32'h7FFFFFFF);
		random_uniforms(10);
		drain();

		// saturated samples push the deviation to its limit
		set_batch(32'd2, 32'h0, 32'h7FFFFFFF);
		random_uniforms(20);
		drain();

		// oversized length acts as the maximum batch, then lowered mid batch
		set_batch(32'h0001FFFF, 32'h7FFFFFFF, 32'h0);
		random_uniforms(30);
		drain();
		set_batch(32'd3, $urandom, 32'd65536);
		write_reg(CFG_UNUSED, $urandom);
		tx_idle_pct = 73;
		random_uniforms(300);
		drain();

		set_batch(32'd7, $urandom_range(32'h000FFFFF), $urandom_range(32'h00100000));
		tx_idle_pct = 0;
		rx_stall_pct = 73;
		random_uniforms(300);
		drain();

		set_batch(32'd16, -$urandom_range(32'h00FFFFFF), $urandom_range(32'h7FFFFFFF));
		tx_idle_pct = 38;
		rx_stall_pct = 38;
		random_uniforms(300);
		drain();

		set_batch(32'd65536, 32'h0, 32'd65536);
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		random_uniforms(20);
		drain();
		set_batch(32'd1000, 32'h0, 32'd65536);
		random_uniforms(300);
		drain();

		if (errors == 0 && pending == 0)
			$display("PASS box_muller_gaussian_generator");
		else
			$display("FAIL box_muller_gaussian_generator");
		$finish;
	end
endmodule

FILE: sim.f
rtl/core/bmg_pkg.sv
rtl/core/bmg_mul.sv
rtl/core/bmg_iter.sv
rtl/core/box_muller_gaussian_generator.sv
tb/bmg_checker.sv
tb/tb_box_muller_gaussian_generator.sv
